// File: rtl/core/wbps_pkg.sv
// wbps_pkg: shared constants, word types and register indexes for the
// wildcard byte pattern scan core. No dependencies.
package wbps_pkg;

    localparam int MAX_PATTERN_BYTES = 32;
    localparam int OFFSET_BITS       = 32;
    localparam int LEN_BITS          = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int IDX_BITS          = $clog2(MAX_PATTERN_BYTES);
    localparam int CFG_DATA_BITS     = 64;
    localparam int CFG_INDEX_BITS    = 3;

    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

    // register indexes of the configuration port
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PATTERN_0_7   = 3'd0,
        REG_PATTERN_8_15  = 3'd1,
        REG_PATTERN_16_23 = 3'd2,
        REG_PATTERN_24_31 = 3'd3,
        REG_CARE_MASK     = 3'd4,
        REG_PATTERN_LEN   = 3'd5
    } cfg_reg_t;

    typedef logic [MAX_PATTERN_BYTES-1:0][7:0] pat_array_t;

    // input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       image_end;
    } in_word_t;

    // result word
    typedef struct packed {
        logic                   found;
        logic [OFFSET_BITS-1:0] match_offset;
    } out_word_t;

endpackage

// File: rtl/core/wbps_cell.sv
// wbps_cell: one window slot; holds a byte, passes it to the next slot on
// every shift and compares it with its aligned pattern byte. Uses wbps_pkg.
module wbps_cell (
    input  logic       aclk,
    input  logic       shift_en,
    input  logic [7:0] din,
    input  logic [7:0] pat_byte,
    input  logic       care,
    output logic [7:0] dout,
    output logic       hit
);
    import wbps_pkg::*;

    logic [7:0] byte_reg;

    // window slot, shifts when a word is accepted
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= din;
        end
    end

    assign dout = byte_reg;
    // wildcard positions always hit
    assign hit  = !care || (byte_reg == pat_byte);

endmodule

// File: rtl/core/wbps_chain.sv
// wbps_chain: row of window cells, newest byte in cell 0, oldest at the end.
// Uses wbps_pkg and wbps_cell.
module wbps_chain (
    input  logic                                      aclk,
    input  logic                                      shift_en,
    input  logic [7:0]                                din,
    input  wbps_pkg::pat_array_t                      pat_al,
    input  logic [wbps_pkg::MAX_PATTERN_BYTES-1:0]    care_al,
    output logic [wbps_pkg::MAX_PATTERN_BYTES-1:0]    hits
);
    import wbps_pkg::*;

    logic [MAX_PATTERN_BYTES:0][7:0] link;

    assign link[0] = din;

    // cell k holds the byte seen k words ago
    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
        wbps_cell u_cell (
            .aclk     (aclk),
            .shift_en (shift_en),
            .din      (link[k]),
            .pat_byte (pat_al[k]),
            .care     (care_al[k]),
            .dout     (link[k+1]),
            .hit      (hits[k])
        );
    end

endmodule

// File: rtl/core/wildcard_byte_pattern_scan_core.sv
// wildcard_byte_pattern_scan_core: top level; configuration registers, pattern
// alignment, byte count, match decision and result register.
// Uses wbps_pkg and wbps_chain.
//
// Takes one image byte per cycle, back to back, and returns one result word per
// image: found with the offset of the first match start, or found clear at the
// image end. The accepting edge shifts the byte into the window of 32 cells and
// into the window stage; the result register then loads from a parallel compare
// of every cell when that stage moves. Input stalls only while a result word
// waits with m_ready low. The pattern, care mask and length are realigned to
// the window in the cycle after a register write, so configure only while no
// image is in progress; a write takes effect for bytes accepted from the cycle
// after it. The byte count saturates at 2^32-1, after which no match is
// reported for that image.
module wildcard_byte_pattern_scan_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration port
    input  logic                                  cfg_wr_en,
    input  logic [wbps_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [wbps_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    // byte input
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  wbps_pkg::in_word_t                    s_word,
    // result output
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output wbps_pkg::out_word_t                   m_word
);
    import wbps_pkg::*;

    // configuration registers
    logic [3:0][CFG_DATA_BITS-1:0]  pattern_reg;
    logic [MAX_PATTERN_BYTES-1:0]   care_reg;
    logic [LEN_BITS-1:0]            len_reg;

    // aligned pattern, one entry per window cell
    pat_array_t                     pat_al_reg, pat_al_next;
    logic [MAX_PATTERN_BYTES-1:0]   care_al_reg, care_al_next;

    // window stage
    logic                           s1_valid_reg;
    logic                           s1_last_reg;
    logic                           s1_sat_ok_reg;
    logic [OFFSET_BITS-1:0]         cnt_reg, cnt_next;
    logic                           match_reported_reg, match_reported_next;

    // result register
    logic                           m_valid_reg, m_valid_next;
    out_word_t                      m_word_reg, m_word_next;

    pat_array_t                     pat_all;
    logic [LEN_BITS-1:0]            len_eff;
    logic [MAX_PATTERN_BYTES-1:0]   hits;
    logic                           s_accept;
    logic                           s1_move;
    logic [OFFSET_BITS-1:0]         cnt_base;
    logic                           sat_ok;
    logic                           len_reached;
    logic                           match_hit;
    logic                           emit;

    // register writes, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            care_reg    <= '1;
            len_reg     <= LEN_BITS'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PATTERN_0_7:   pattern_reg[0] <= cfg_wdata;
                REG_PATTERN_8_15:  pattern_reg[1] <= cfg_wdata;
                REG_PATTERN_16_23: pattern_reg[2] <= cfg_wdata;
                REG_PATTERN_24_31: pattern_reg[3] <= cfg_wdata;
                REG_CARE_MASK:     care_reg <= cfg_wdata[MAX_PATTERN_BYTES-1:0];
                REG_PATTERN_LEN:   len_reg  <= cfg_wdata[LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign pat_all = pattern_reg;

    // clamp length to 1..MAX_PATTERN_BYTES
    always_comb begin
        if (len_reg == '0) begin
            len_eff = LEN_BITS'(1);
        end else if (len_reg > LEN_BITS'(MAX_PATTERN_BYTES)) begin
            len_eff = LEN_BITS'(MAX_PATTERN_BYTES);
        end else begin
            len_eff = len_reg;
        end
    end

    // cell k faces pattern byte len-1-k; cells past the length are wildcards
    always_comb begin
        logic [LEN_BITS-1:0] pos;
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            pos = len_eff - LEN_BITS'(1) - LEN_BITS'(k);
            if (LEN_BITS'(k) < len_eff) begin
                pat_al_next[k]  = pat_all[pos[IDX_BITS-1:0]];
                care_al_next[k] = care_reg[pos[IDX_BITS-1:0]];
            end else begin
                pat_al_next[k]  = '0;
                care_al_next[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pat_al_reg  <= pat_al_next;
        care_al_reg <= care_al_next;
    end

    // handshake: the window stage moves when the result register can take it
    assign s1_move  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_move;
    assign s_accept = s_valid && s_ready;

    wbps_chain u_chain (
        .aclk     (aclk),
        .shift_en (s_accept),
        .din      (s_word.data_byte),
        .pat_al   (pat_al_reg),
        .care_al  (care_al_reg),
        .hits     (hits)
    );

    // byte count, restarted after an image end
    assign cnt_base = s1_last_reg ? '0 : cnt_reg;
    assign sat_ok   = (cnt_base != COUNT_MAX);
    assign cnt_next = sat_ok ? cnt_base + OFFSET_BITS'(1) : cnt_base;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            s1_sat_ok_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            if (s_accept) begin
                s1_valid_reg  <= 1'b1;
                s1_last_reg   <= s_word.image_end;
                s1_sat_ok_reg <= sat_ok;
                cnt_reg       <= cnt_next;
            end else if (s1_move) begin
                s1_valid_reg  <= 1'b0;
            end
        end
    end

    // match decision on the window holding the staged byte
    assign len_reached = (cnt_reg >= OFFSET_BITS'(len_eff));
    assign match_hit   = (&hits) && s1_sat_ok_reg && len_reached && !match_reported_reg;
    assign emit        = match_hit || (s1_last_reg && !match_reported_reg);

    always_comb begin
        match_reported_next = match_reported_reg;
        m_valid_next        = m_valid_reg;
        m_word_next         = m_word_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s1_move) begin
            if (s1_last_reg) begin
                match_reported_next = 1'b0;
            end else if (match_hit) begin
                match_reported_next = 1'b1;
            end
            if (emit) begin
                m_valid_next             = 1'b1;
                m_word_next.found        = match_hit;
                m_word_next.match_offset = match_hit ? cnt_reg - OFFSET_BITS'(len_eff) : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reported_reg <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            match_reported_reg <= match_reported_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_word_reg <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    // checks
    a_nofind_zero_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_word_reg.found |-> m_word_reg.match_offset == '0)
        else $error("result without match carries a nonzero offset");

    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_move && s1_last_reg |=> !match_reported_reg)
        else $error("match flag survives an image end");

    a_match_needs_len: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_move && match_hit |-> cnt_reg >= OFFSET_BITS'(len_eff))
        else $error("match reported before a full pattern was seen");

    a_empty_stage_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_valid_reg |-> s_ready)
        else $error("input stalled with an empty window stage");

    a_one_per_image: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_move && match_reported_reg |-> !emit)
        else $error("second result for one image");

endmodule
